[sv/cpp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared widths, constants and types of the closest point on polyline block.
// ----------------------------------------------------------------------------
package cpp_pkg;

   localparam int CoordFracBits = 8;
   localparam int PosFracBits   = 16;

   localparam int CoordW = 32;
   localparam int MagW   = CoordW + 1;
   localparam int MulW   = 35;
   localparam int ProdW  = 2 * MulW;
   localparam int WideW  = 68;
   localparam int TW     = PosFracBits + 1;
   localparam int DistW  = 33;
   localparam int ArcW   = 48;
   localparam int RootW  = ProdW / 2;
   localparam int PieceW = 37;
   localparam int RLen   = CoordW + 2;

   localparam logic [TW-1:0]    OneT    = TW'(1) << PosFracBits;
   localparam logic [ProdW-1:0] HalfT   = ProdW'(1) << (PosFracBits - 1);
   localparam logic [DistW-1:0] DistMax = '1;
   localparam logic [ArcW-1:0]  ArcMax  = '1;
   localparam logic [WideW-1:0] EpsLen2 =
      WideW'((64'd1 << (2 * CoordFracBits)) / 64'd100000000);
   localparam logic [ArcW-1:0]  EpsLen  =
      ArcW'((64'd1 << CoordFracBits) / 64'd100000000);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_SETUP  = 14'b00000000000010,
      S_MUL_GO = 14'b00000000000100,
      S_MUL_W  = 14'b00000000001000,
      S_TSEL   = 14'b00000000010000,
      S_DIV    = 14'b00000000100000,
      S_SQD    = 14'b00000001000000,
      S_SQD_W  = 14'b00000010000000,
      S_SQL    = 14'b00000100000000,
      S_SQL_W  = 14'b00001000000000,
      S_UPD    = 14'b00010000000000,
      S_FINISH = 14'b00100000000000,
      S_ARC    = 14'b01000000000000,
      S_LOAD   = 14'b10000000000000
   } state_type;

   typedef enum logic [2:0] {
      P_LEN2,
      P_DOT,
      P_CAND,
      P_D2,
      P_PIECE
   } phase_type;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

endpackage
`default_nettype wire

[sv/cpp_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpp_mul
// Bit-serial shift-add multiplier, multiplier bits taken MSB first.
// ----------------------------------------------------------------------------
module cpp_mul import cpp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [MulW-1:0]  mul_a,
   input  wire logic [MulW-1:0]  mul_b,
   output logic                  done,
   output logic [ProdW-1:0]      product
);

   logic [5:0]       cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic [MulW-1:0]  a_ff;
   logic [MulW-1:0]  b_ff;
   logic [ProdW-1:0] p_ff;
   logic [ProdW-1:0] p_in;

   assign p_in = {p_ff[ProdW-2:0], 1'b0} + (b_ff[MulW-1] ? ProdW'(a_ff) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'(MulW);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= mul_a;
         b_ff <= mul_b;
         p_ff <= '0;
      end else if (run_ff) begin
         b_ff <= {b_ff[MulW-2:0], 1'b0};
         p_ff <= p_in;
      end
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule
`default_nettype wire

[sv/cpp_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpp_sqrt
// Restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module cpp_sqrt import cpp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [ProdW-1:0]  radicand,
   output logic                   done,
   output logic [RootW-1:0]       root
);

   localparam int RemW = RootW + 3;

   logic [5:0]       cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic [ProdW-1:0] rad_ff;
   logic [RemW-1:0]  rem_ff;
   logic [RootW-1:0] root_ff;
   logic [RemW-1:0]  rem_sh;
   logic [RemW-1:0]  trial;

   assign rem_sh = {rem_ff[RemW-3:0], rad_ff[ProdW-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'(RootW);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff <= {rad_ff[ProdW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[RootW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[RootW-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

[sv/closest_point_on_polyline.sv]
`default_nettype none
// Stalls: after a transfer the input stalls until the vertex is done. A vertex that opens a
// polyline only stores state; one that closes a segment runs 13 serial multiplies, two serial
// square roots, a serial divide when t falls inside the segment, and control states. A last
// vertex adds the arc division when needed, plus any wait for the output register.
// Throughput: one vertex at a time; req_stall is high whenever the control is not idle.
// Reset: synchronous, active high; clears control and the running polyline state.
// ----------------------------------------------------------------------------
// closest_point_on_polyline
// Streams a 3D polyline and reports the closest point to a query point, its
// distance and its normalized arc position.
// ----------------------------------------------------------------------------
module closest_point_on_polyline import cpp_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [CoordW-1:0]  req_vertex_x,
   input  wire logic signed [CoordW-1:0]  req_vertex_y,
   input  wire logic signed [CoordW-1:0]  req_vertex_z,
   input  wire logic signed [CoordW-1:0]  req_query_x,
   input  wire logic signed [CoordW-1:0]  req_query_y,
   input  wire logic signed [CoordW-1:0]  req_query_z,
   input  wire logic                      req_first_vertex,
   input  wire logic                      req_last_vertex,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_found,
   output logic signed [CoordW-1:0]       rsp_closest_x,
   output logic signed [CoordW-1:0]       rsp_closest_y,
   output logic signed [CoordW-1:0]       rsp_closest_z,
   output logic [DistW-1:0]               rsp_distance,
   output logic [TW-1:0]                  rsp_arc_position
);

   state_type         state_ff;
   phase_type         phase_ff;
   logic [1:0]        lane_ff;

   logic [CoordW-1:0] cur_ff   [3];
   logic [CoordW-1:0] prev_ff  [3];
   logic [CoordW-1:0] query_ff [3];
   logic [CoordW-1:0] best_pt_ff [3];
   logic [CoordW-1:0] cand_ff  [3];
   logic              last_ff;
   logic [1:0]        seen_ff;
   logic [DistW-1:0]  best_dist_ff;
   logic [ArcW-1:0]   best_arc_ff;
   logic [ArcW-1:0]   arc_ff;

   logic [MagW-1:0]   seg_mag_ff [3];
   logic              seg_neg_ff [3];
   logic [MagW-1:0]   rel_mag_ff [3];
   logic              rel_neg_ff [3];
   logic [MagW-1:0]   seg_mag_in [3];
   logic              seg_neg_in [3];
   logic [MagW-1:0]   rel_mag_in [3];
   logic              rel_neg_in [3];

   logic [WideW-1:0]  len2_ff;
   logic [WideW-1:0]  dot_ff;
   logic [WideW-1:0]  d2_ff;
   logic [TW-1:0]     t_ff;
   logic [DistW-1:0]  dist_ff;
   logic [RootW-1:0]  seglen_ff;
   logic [PieceW-1:0] piece_ff;
   logic [TW-1:0]     frac_ff;
   logic              found_ff;

   logic [WideW-1:0]  num_ff;
   logic [WideW-1:0]  den_ff;
   logic [PosFracBits-1:0] q_ff;
   logic [4:0]        dcnt_ff;
   logic              div_arc_ff;
   logic [WideW:0]    num_sh;
   logic              div_take;
   logic [PosFracBits-1:0] q_in;

   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [CoordW-1:0] rsp_pt_ff [3];
   logic [DistW-1:0]  rsp_dist_ff;
   logic [TW-1:0]     rsp_arc_ff;

   unit_ctl_type      mul_ctl;
   unit_ctl_type      sqrt_ctl;
   logic [MulW-1:0]   mul_a;
   logic [MulW-1:0]   mul_b;
   logic [ProdW-1:0]  product;
   logic [ProdW-1:0]  rnd;
   logic [ProdW-1:0]  sqrt_rad;
   logic [RootW-1:0]  root;

   logic [MagW-1:0]   diff;
   logic [MagW-1:0]   diff_mag;
   logic [RLen-1:0]   r_part;
   logic [RLen-1:0]   prev_ext;
   logic [RLen-1:0]   cand_ext;
   logic [ArcW:0]     arc_piece;
   logic [ArcW:0]     arc_total;
   logic [ArcW-1:0]   arc_new;

   logic              accept;
   logic              restart;
   logic              out_free;
   logic              clear_run;
   logic [1:0]        seen_next;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign restart   = req_first_vertex || (seen_ff == 2'd0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign clear_run = (state_ff == S_LOAD) && out_free;
   assign seen_next = (seen_ff == 2'd2) ? 2'd2 : seen_ff + 2'd1;

   always_comb begin
      logic [MagW-1:0] seg;
      logic [MagW-1:0] rel;
      for (int i = 0; i < 3; i++) begin
         seg = {cur_ff[i][CoordW-1], cur_ff[i]} - {prev_ff[i][CoordW-1], prev_ff[i]};
         rel = {query_ff[i][CoordW-1], query_ff[i]} - {prev_ff[i][CoordW-1], prev_ff[i]};
         seg_neg_in[i] = seg[MagW-1];
         rel_neg_in[i] = rel[MagW-1];
         seg_mag_in[i] = seg[MagW-1] ? -seg : seg;
         rel_mag_in[i] = rel[MagW-1] ? -rel : rel;
      end
   end

   assign diff     = {cand_ff[lane_ff][CoordW-1], cand_ff[lane_ff]}
                   - {query_ff[lane_ff][CoordW-1], query_ff[lane_ff]};
   assign diff_mag = diff[MagW-1] ? -diff : diff;

   always_comb begin
      mul_a = MulW'(seg_mag_ff[lane_ff]);
      mul_b = MulW'(seg_mag_ff[lane_ff]);
      case (phase_ff)
         P_LEN2: begin
         end
         P_DOT: begin
            mul_b = MulW'(rel_mag_ff[lane_ff]);
         end
         P_CAND: begin
            mul_b = MulW'(t_ff);
         end
         P_D2: begin
            mul_a = MulW'(diff_mag);
            mul_b = MulW'(diff_mag);
         end
         P_PIECE: begin
            mul_a = seglen_ff;
            mul_b = MulW'(t_ff);
         end
         default: begin
         end
      endcase
   end

   assign mul_ctl.start  = (state_ff == S_MUL_GO);
   assign sqrt_ctl.start = (state_ff == S_SQD) || (state_ff == S_SQL);
   assign sqrt_rad       = (state_ff == S_SQD) ? ProdW'(d2_ff) : ProdW'(len2_ff);

   cpp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_ctl.start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_ctl.done),
      .product (product)
   );

   cpp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_ctl.start),
      .radicand (sqrt_rad),
      .done     (sqrt_ctl.done),
      .root     (root)
   );

   // round half away from zero on the magnitude
   assign rnd      = product + HalfT;
   assign r_part   = rnd[PosFracBits +: RLen];
   assign prev_ext = {{2{prev_ff[lane_ff][CoordW-1]}}, prev_ff[lane_ff]};
   assign cand_ext = seg_neg_ff[lane_ff] ? prev_ext - r_part : prev_ext + r_part;

   assign num_sh   = {num_ff, 1'b0};
   assign div_take = (num_sh >= {1'b0, den_ff});
   assign q_in     = {q_ff[PosFracBits-2:0], div_take};

   assign arc_piece = {1'b0, arc_ff} + (ArcW+1)'(piece_ff);
   assign arc_total = {1'b0, arc_ff} + (ArcW+1)'(seglen_ff);
   assign arc_new   = arc_piece[ArcW] ? ArcMax : arc_piece[ArcW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= P_LEN2;
         lane_ff      <= '0;
         seen_ff      <= '0;
         best_dist_ff <= DistMax;
         best_arc_ff  <= '0;
         arc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i]    <= '0;
            query_ff[i]   <= '0;
            best_pt_ff[i] <= '0;
         end
      end else begin
         if (clear_run) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (restart) begin
                     seen_ff      <= '0;
                     best_dist_ff <= DistMax;
                     best_arc_ff  <= '0;
                     arc_ff       <= '0;
                     for (int i = 0; i < 3; i++) begin
                        best_pt_ff[i] <= '0;
                     end
                     query_ff[0] <= req_query_x;
                     query_ff[1] <= req_query_y;
                     query_ff[2] <= req_query_z;
                     state_ff    <= S_FINISH;
                  end else begin
                     state_ff <= S_SETUP;
                  end
               end
            end
            S_SETUP: begin
               phase_ff <= P_LEN2;
               lane_ff  <= '0;
               state_ff <= S_MUL_GO;
            end
            S_MUL_GO: begin
               state_ff <= S_MUL_W;
            end
            S_MUL_W: begin
               if (mul_ctl.done) begin
                  if (lane_ff != 2'd2 && phase_ff != P_PIECE) begin
                     lane_ff  <= lane_ff + 2'd1;
                     state_ff <= S_MUL_GO;
                  end else begin
                     lane_ff <= '0;
                     case (phase_ff)
                        P_LEN2: begin
                           phase_ff <= P_DOT;
                           state_ff <= S_MUL_GO;
                        end
                        P_DOT: begin
                           state_ff <= S_TSEL;
                        end
                        P_CAND: begin
                           phase_ff <= P_D2;
                           state_ff <= S_MUL_GO;
                        end
                        P_D2: begin
                           state_ff <= S_SQD;
                        end
                        P_PIECE: begin
                           state_ff <= S_UPD;
                        end
                        default: begin
                           state_ff <= S_IDLE;
                        end
                     endcase
                  end
               end
            end
            S_TSEL: begin
               if (len2_ff <= EpsLen2 || dot_ff[WideW-1] || dot_ff == '0
                   || dot_ff >= len2_ff) begin
                  phase_ff <= P_CAND;
                  state_ff <= S_MUL_GO;
               end else begin
                  dcnt_ff  <= 5'(PosFracBits);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               dcnt_ff <= dcnt_ff - 5'd1;
               if (dcnt_ff == 5'd1) begin
                  if (div_arc_ff) begin
                     state_ff <= S_LOAD;
                  end else begin
                     phase_ff <= P_CAND;
                     state_ff <= S_MUL_GO;
                  end
               end
            end
            S_SQD: begin
               state_ff <= S_SQD_W;
            end
            S_SQD_W: begin
               if (sqrt_ctl.done) begin
                  state_ff <= S_SQL;
               end
            end
            S_SQL: begin
               state_ff <= S_SQL_W;
            end
            S_SQL_W: begin
               if (sqrt_ctl.done) begin
                  phase_ff <= P_PIECE;
                  state_ff <= S_MUL_GO;
               end
            end
            S_UPD: begin
               if (seen_ff == 2'd1 || dist_ff < best_dist_ff) begin
                  best_dist_ff <= dist_ff;
                  best_arc_ff  <= arc_new;
                  for (int i = 0; i < 3; i++) begin
                     best_pt_ff[i] <= cand_ff[i];
                  end
               end
               arc_ff   <= arc_total[ArcW] ? ArcMax : arc_total[ArcW-1:0];
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               for (int i = 0; i < 3; i++) begin
                  prev_ff[i] <= cur_ff[i];
               end
               seen_ff  <= seen_next;
               state_ff <= last_ff ? S_ARC : S_IDLE;
            end
            S_ARC: begin
               if (seen_ff == 2'd2 && arc_ff > EpsLen && best_arc_ff < arc_ff) begin
                  dcnt_ff  <= 5'(PosFracBits);
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               if (out_free) begin
                  seen_ff      <= '0;
                  best_dist_ff <= DistMax;
                  best_arc_ff  <= '0;
                  arc_ff       <= '0;
                  for (int i = 0; i < 3; i++) begin
                     best_pt_ff[i] <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_ff[0] <= req_vertex_x;
               cur_ff[1] <= req_vertex_y;
               cur_ff[2] <= req_vertex_z;
               last_ff   <= req_last_vertex;
            end
         end
         S_SETUP: begin
            for (int i = 0; i < 3; i++) begin
               seg_mag_ff[i] <= seg_mag_in[i];
               seg_neg_ff[i] <= seg_neg_in[i];
               rel_mag_ff[i] <= rel_mag_in[i];
               rel_neg_ff[i] <= rel_neg_in[i];
            end
            len2_ff <= '0;
            dot_ff  <= '0;
            d2_ff   <= '0;
         end
         S_MUL_W: begin
            if (mul_ctl.done) begin
               case (phase_ff)
                  P_LEN2: begin
                     len2_ff <= len2_ff + product[WideW-1:0];
                  end
                  P_DOT: begin
                     if (seg_neg_ff[lane_ff] ^ rel_neg_ff[lane_ff]) begin
                        dot_ff <= dot_ff - product[WideW-1:0];
                     end else begin
                        dot_ff <= dot_ff + product[WideW-1:0];
                     end
                  end
                  P_CAND: begin
                     cand_ff[lane_ff] <= cand_ext[CoordW-1:0];
                  end
                  P_D2: begin
                     d2_ff <= d2_ff + product[WideW-1:0];
                  end
                  P_PIECE: begin
                     piece_ff <= rnd[PosFracBits +: PieceW];
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TSEL: begin
            if (len2_ff <= EpsLen2 || dot_ff[WideW-1] || dot_ff == '0) begin
               t_ff <= '0;
            end else if (dot_ff >= len2_ff) begin
               t_ff <= OneT;
            end else begin
               num_ff     <= dot_ff;
               den_ff     <= len2_ff;
               q_ff       <= '0;
               div_arc_ff <= 1'b0;
            end
         end
         S_DIV: begin
            num_ff <= div_take ? WideW'(num_sh - {1'b0, den_ff}) : num_sh[WideW-1:0];
            q_ff   <= q_in;
            if (dcnt_ff == 5'd1) begin
               if (div_arc_ff) begin
                  frac_ff <= TW'(q_in);
               end else begin
                  t_ff <= TW'(q_in);
               end
            end
         end
         S_SQD_W: begin
            if (sqrt_ctl.done) begin
               dist_ff <= (root > RootW'(DistMax)) ? DistMax : root[DistW-1:0];
            end
         end
         S_SQL_W: begin
            if (sqrt_ctl.done) begin
               seglen_ff <= root;
            end
         end
         S_ARC: begin
            found_ff <= (seen_ff == 2'd2);
            if (arc_ff <= EpsLen) begin
               frac_ff <= '0;
            end else if (best_arc_ff >= arc_ff) begin
               frac_ff <= OneT;
            end else begin
               num_ff     <= WideW'(best_arc_ff);
               den_ff     <= WideW'(arc_ff);
               q_ff       <= '0;
               div_arc_ff <= 1'b1;
            end
         end
         S_LOAD: begin
            if (out_free) begin
               rsp_found_ff <= found_ff;
               rsp_dist_ff  <= found_ff ? best_dist_ff : '0;
               rsp_arc_ff   <= found_ff ? frac_ff : '0;
               for (int i = 0; i < 3; i++) begin
                  rsp_pt_ff[i] <= found_ff ? best_pt_ff[i] : '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_closest_x    = rsp_pt_ff[0];
   assign rsp_closest_y    = rsp_pt_ff[1];
   assign rsp_closest_z    = rsp_pt_ff[2];
   assign rsp_distance     = rsp_dist_ff;
   assign rsp_arc_position = rsp_arc_ff;

endmodule
`default_nettype wire
